>>> src/fppd_pkg.sv
// Package: shared constants, types and helpers of the form parameter percent decoder.
`default_nettype none
package fppd_pkg;

  localparam logic [7:0] CHAR_EQ      = 8'h3d;
  localparam logic [7:0] CHAR_AMP     = 8'h26;
  localparam logic [7:0] CHAR_PERCENT = 8'h25;
  localparam logic [7:0] CHAR_QMARK   = 8'h3f;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_NUL     = 8'h00;

  localparam logic [7:0] NAME_CAP_RST  = 8'd32;
  localparam logic [7:0] VALUE_CAP_RST = 8'd64;

  localparam logic [1:0] KIND_NAME  = 2'd0;
  localparam logic [1:0] KIND_VALUE = 2'd1;
  localparam logic [1:0] KIND_NONE  = 2'd2;

  localparam logic [1:0] CFG_NAME_CAP  = 2'd0;
  localparam logic [1:0] CFG_VALUE_CAP = 2'd1;
  localparam logic [1:0] CFG_BODY_MODE = 2'd2;

  typedef enum logic [2:0] {
    ESC_IDLE = 3'b001,
    ESC_HI   = 3'b010,
    ESC_LO   = 3'b100
  } esc_state_e;

  // bit 4 = valid hex digit, bits 3..0 = digit value
  typedef logic [4:0] hex_digit_t;

  function automatic logic is_ws(input logic [7:0] c);
    is_ws = (c == CHAR_SPACE) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic hex_digit_t hex_value(input logic [7:0] c);
    hex_digit_t r;
    r = 5'd0;
    if ((c >= 8'h30) && (c <= 8'h39)) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if ((c >= 8'h61) && (c <= 8'h66)) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if ((c >= 8'h41) && (c <= 8'h46)) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    hex_value = r;
  endfunction

endpackage
`default_nettype wire

>>> src/form_param_percent_decoder.sv
// Top level: streaming name=value splitter with percent-escape decoding.
//
//  channel | direction | handshake               | payload
//  in      | sink      | in_valid_i / in_stall_o | in_byte_i, end_of_input_i
//  out     | source    | out_valid_o/out_stall_i | out_byte_o, out_kind_o,
//          |           |                         | param_end_o, name_complete_o
//  cfg     | sink      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One item per cycle while in_stall_o is low; a result appears in the cycle after its item is accepted.
// Parser state updates and the result register load at the same edge.
// in_stall_o is high only while a held result is stalled downstream.
// Reset loads default capacities, clears escape state and the result valid flag.
// cfg_ready_o is always high.
`default_nettype none
module form_param_percent_decoder (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       end_of_input_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic [1:0]      out_kind_o,
  output logic            param_end_o,
  output logic            name_complete_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [7:0] cfg_data_i
);

  logic [7:0] name_cap_q, value_cap_q;
  logic       body_mode_q;

  logic [7:0] name_left_q, name_left_d;
  logic [7:0] value_left_q, value_left_d;
  logic       name_seen_q, name_seen_d;
  fppd_pkg::esc_state_e esc_q, esc_d;
  fppd_pkg::hex_digit_t first_digit_q, first_digit_d;

  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic [1:0] out_kind_q;
  logic       param_end_q, name_complete_q;

  logic       in_acc, drop, silent, store, end_p, emit, complete;
  logic [7:0] data;
  logic [1:0] kind;
  fppd_pkg::hex_digit_t hx;

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign hx          = fppd_pkg::hex_value(in_byte_i);

  always_comb begin
    name_left_d   = name_left_q;
    value_left_d  = value_left_q;
    name_seen_d   = name_seen_q;
    esc_d         = esc_q;
    first_digit_d = first_digit_q;
    drop          = 1'b0;
    silent        = 1'b0;
    store         = 1'b0;
    end_p         = 1'b0;
    data          = 8'd0;
    kind          = fppd_pkg::KIND_NONE;
    complete      = 1'b0;

    if (!end_of_input_i && body_mode_q &&
        (fppd_pkg::is_ws(in_byte_i) || in_byte_i == fppd_pkg::CHAR_QMARK)) begin
      drop = 1'b1;
    end else if (end_of_input_i || in_byte_i == fppd_pkg::CHAR_NUL) begin
      end_p = 1'b1;
    end else begin
      unique case (esc_q)
        fppd_pkg::ESC_HI: begin
          first_digit_d = hx;
          esc_d         = fppd_pkg::ESC_LO;
          silent        = 1'b1;
        end
        fppd_pkg::ESC_LO: begin
          if (first_digit_q[4]) begin
            data = hx[4] ? {first_digit_q[3:0], hx[3:0]} : {4'd0, first_digit_q[3:0]};
          end
          esc_d         = fppd_pkg::ESC_IDLE;
          first_digit_d = 5'd0;
          store         = 1'b1;
        end
        default: begin
          if (in_byte_i == fppd_pkg::CHAR_EQ) begin
            name_left_d = 8'd0;
          end else if (in_byte_i == fppd_pkg::CHAR_AMP || fppd_pkg::is_ws(in_byte_i)) begin
            end_p = name_seen_q;
          end else if (in_byte_i == fppd_pkg::CHAR_PERCENT) begin
            esc_d  = fppd_pkg::ESC_HI;
            silent = 1'b1;
          end else begin
            data  = in_byte_i;
            store = 1'b1;
          end
        end
      endcase
    end

    if (store) begin
      if (name_left_q != 8'd0) begin
        kind        = fppd_pkg::KIND_NAME;
        name_seen_d = 1'b1;
        name_left_d = name_left_q - 8'd1;
      end else begin
        kind = fppd_pkg::KIND_VALUE;
        if (value_left_q != 8'd0) begin
          value_left_d = value_left_q - 8'd1;
        end
      end
    end

    if (!drop && !silent && !end_p && value_left_d == 8'd0) begin
      end_p = 1'b1;
    end

    if (end_p) begin
      complete      = (name_left_d == 8'd0);
      name_left_d   = name_cap_q;
      value_left_d  = value_cap_q;
      name_seen_d   = 1'b0;
      esc_d         = fppd_pkg::ESC_IDLE;
      first_digit_d = 5'd0;
    end

    emit = !drop && !silent && (store || end_p);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name_cap_q  <= fppd_pkg::NAME_CAP_RST;
      value_cap_q <= fppd_pkg::VALUE_CAP_RST;
      body_mode_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        fppd_pkg::CFG_NAME_CAP:  name_cap_q  <= cfg_data_i;
        fppd_pkg::CFG_VALUE_CAP: value_cap_q <= cfg_data_i;
        fppd_pkg::CFG_BODY_MODE: body_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name_left_q   <= fppd_pkg::NAME_CAP_RST;
      value_left_q  <= fppd_pkg::VALUE_CAP_RST;
      name_seen_q   <= 1'b0;
      esc_q         <= fppd_pkg::ESC_IDLE;
      first_digit_q <= 5'd0;
    end else if (in_acc) begin
      name_left_q   <= name_left_d;
      value_left_q  <= value_left_d;
      name_seen_q   <= name_seen_d;
      esc_q         <= esc_d;
      first_digit_q <= first_digit_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= emit;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && emit) begin
      out_byte_q      <= data;
      out_kind_q      <= kind;
      param_end_q     <= end_p;
      name_complete_q <= complete;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = out_byte_q;
  assign out_kind_o      = out_kind_q;
  assign param_end_o     = param_end_q;
  assign name_complete_o = name_complete_q;

  a_result_meaningful: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_kind_q != fppd_pkg::KIND_NONE) || param_end_q)
    else $error("result with neither byte nor parameter end");

  a_complete_with_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && name_complete_q |-> param_end_q)
    else $error("name_complete without param_end");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_kind_q != 2'd3)
    else $error("illegal out_kind");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && emit && end_p |=> esc_q == fppd_pkg::ESC_IDLE && !name_seen_q &&
      first_digit_q == 5'd0)
    else $error("state not restarted after parameter end");

  a_escape_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && esc_q == fppd_pkg::ESC_HI && !end_of_input_i && in_byte_i != 8'd0 &&
      !drop |-> !emit)
    else $error("first escape digit produced a result");

endmodule
`default_nettype wire

>>> tb/sv/fppd_param_monitor.sv
// Monitor: predicts decoder results from accepted items and checks each accepted result.
module fppd_param_monitor (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_input_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] out_byte_i,
  input  logic [1:0] out_kind_i,
  input  logic       param_end_i,
  input  logic       name_complete_i,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  output int         mismatch_count_o,
  output int         awaited_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] WAIT_NONE = 2'd0;
  localparam logic [1:0] WAIT_HIGH = 2'd1;
  localparam logic [1:0] WAIT_LOW  = 2'd2;
  localparam int         REPORT_LIMIT = 10;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic       done;
    logic       named;
  } param_result_t;

  logic [7:0]    name_cap;
  logic [7:0]    value_cap;
  logic          body_sel;
  logic [7:0]    name_left;
  logic [7:0]    value_left;
  logic          name_seen;
  logic [1:0]    esc_phase;
  logic [4:0]    first_digit;
  param_result_t awaited_q[$];

  function automatic logic is_blank(input logic [7:0] c);
    return (c == fppd_pkg::CHAR_SPACE) || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  // bit 4 set when c is a hex digit
  function automatic logic [4:0] hex_of(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b1, 4'(c - 8'h30)};
    if (c >= 8'h61 && c <= 8'h66) return {1'b1, 4'(c - 8'h61 + 8'd10)};
    if (c >= 8'h41 && c <= 8'h46) return {1'b1, 4'(c - 8'h41 + 8'd10)};
    return 5'd0;
  endfunction

  function automatic void restart_param();
    name_left   = name_cap;
    value_left  = value_cap;
    name_seen   = 1'b0;
    esc_phase   = WAIT_NONE;
    first_digit = 5'd0;
  endfunction

  // Advances the parser by one item; returns 1 when the item produces a result.
  function automatic bit parse_byte(input logic [7:0] c, input logic eoi,
                                    output param_result_t res);
    logic       ended;
    logic       store;
    logic [7:0] data;
    logic [4:0] h;
    res   = '0;
    ended = 1'b0;
    store = 1'b0;
    data  = 8'd0;
    res.kind = fppd_pkg::KIND_NONE;
    if (!eoi && body_sel && (is_blank(c) || c == fppd_pkg::CHAR_QMARK)) return 0;
    if (eoi || c == fppd_pkg::CHAR_NUL) begin
      ended = 1'b1;
    end else if (esc_phase == WAIT_HIGH) begin
      first_digit = hex_of(c);
      esc_phase   = WAIT_LOW;
      return 0;
    end else if (esc_phase == WAIT_LOW) begin
      h = hex_of(c);
      if (!first_digit[4]) data = 8'd0;
      else if (h[4]) data = {first_digit[3:0], h[3:0]};
      else data = {4'd0, first_digit[3:0]};
      esc_phase   = WAIT_NONE;
      first_digit = 5'd0;
      store       = 1'b1;
    end else if (c == fppd_pkg::CHAR_EQ) begin
      name_left = 8'd0;
    end else if (c == fppd_pkg::CHAR_AMP || is_blank(c)) begin
      if (name_seen) ended = 1'b1;
    end else if (c == fppd_pkg::CHAR_PERCENT) begin
      esc_phase = WAIT_HIGH;
      return 0;
    end else begin
      data  = c;
      store = 1'b1;
    end
    if (store) begin
      res.data = data;
      if (name_left != 0) begin
        res.kind  = fppd_pkg::KIND_NAME;
        name_seen = 1'b1;
        name_left--;
      end else begin
        res.kind = fppd_pkg::KIND_VALUE;
        if (value_left != 0) value_left--;
      end
    end
    if (!ended && value_left == 0) ended = 1'b1;
    if (ended) begin
      res.done  = 1'b1;
      res.named = (name_left == 0);
      restart_param();
    end
    return (res.kind != fppd_pkg::KIND_NONE) || ended;
  endfunction

  task automatic note_mismatch(input string what, input param_result_t exp,
                               input param_result_t act);
    mismatch_count_o++;
    if (mismatch_count_o <= REPORT_LIMIT)
      $display("%0t: %s: expected byte %02h kind %0d end %0b named %0b,",
               $time, what, exp.data, exp.kind, exp.done, exp.named,
               " got byte %02h kind %0d end %0b named %0b",
               act.data, act.kind, act.done, act.named);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    param_result_t got;
    param_result_t exp;
    param_result_t res;
    if (!rst_ni) begin
      name_cap  = fppd_pkg::NAME_CAP_RST;
      value_cap = fppd_pkg::VALUE_CAP_RST;
      body_sel  = 1'b0;
      restart_param();
      awaited_q.delete();
      awaited_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = '{out_byte_i, out_kind_i, param_end_i, name_complete_i};
        if (awaited_q.size() == 0) begin
          note_mismatch("result with nothing awaited", '0, got);
        end else begin
          exp = awaited_q.pop_front();
          if (got !== exp) note_mismatch("result mismatch", exp, got);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          fppd_pkg::CFG_NAME_CAP:  name_cap  = cfg_data_i;
          fppd_pkg::CFG_VALUE_CAP: value_cap = cfg_data_i;
          fppd_pkg::CFG_BODY_MODE: body_sel  = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        if (parse_byte(in_byte_i, end_of_input_i, res)) awaited_q.push_back(res);
      end
      awaited_count_o = awaited_q.size();
    end
  end

  initial mismatch_count_o = 0;

endmodule

>>> tb/sv/testbench.sv
// Top of the decoder regression: clock, reset, stimulus, output stalls and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF      = 10;
  localparam int RESET_CYCLES  = 10;
  localparam int IDLE_LIMIT    = 3000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_ITEMS   = 56;
  localparam int PHASES        = 12;
  localparam int HOLD_PHASE    = 3;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] in_byte_i;
  logic       end_of_input_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] out_byte_o;
  logic [1:0] out_kind_o;
  logic       param_end_o;
  logic       name_complete_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [7:0] cfg_data_i;

  int mismatches;
  int awaited;
  int quiet_cycles = 0;
  int burst_left;
  int gap_max;
  int items_sent;
  bit hold_req;

  always #CLK_HALF clk_i = ~clk_i;

  form_param_percent_decoder DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_byte_i      (in_byte_i),
    .end_of_input_i (end_of_input_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .out_kind_o     (out_kind_o),
    .param_end_o    (param_end_o),
    .name_complete_o(name_complete_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  fppd_param_monitor param_monitor (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .in_byte_i       (in_byte_i),
    .end_of_input_i  (end_of_input_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_i      (out_byte_o),
    .out_kind_i      (out_kind_o),
    .param_end_i     (param_end_o),
    .name_complete_i (name_complete_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .mismatch_count_o(mismatches),
    .awaited_count_o (awaited)
  );

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Output stall pattern; a hold request freezes the output for a long stretch.
  initial begin
    int stall_pct;
    int pattern_left;
    stall_pct    = 0;
    pattern_left = 0;
    out_stall_i  = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        if (pattern_left == 0) begin
          pattern_left = $urandom_range(10, 80);
          case ($urandom_range(0, 4))
            0, 1: stall_pct = 0;
            2: stall_pct = 30;
            3: stall_pct = 60;
            default: stall_pct = 90;
          endcase
        end
        pattern_left--;
        out_stall_i <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  task automatic send_item(input logic [7:0] c, input logic eoi);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gap_max > 0) idle_cycles($urandom_range(0, gap_max));
    end
    burst_left--;
    items_sent++;
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    in_byte_i      <= c;
    end_of_input_i <= eoi;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  task automatic set_reg(input logic [1:0] idx, input logic [7:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_caps(input logic [7:0] name_cap, input logic [7:0] value_cap,
                          input logic body);
    set_reg(fppd_pkg::CFG_NAME_CAP, name_cap);
    set_reg(fppd_pkg::CFG_VALUE_CAP, value_cap);
    set_reg(fppd_pkg::CFG_BODY_MODE, {7'd0, body});
  endtask

  task automatic wait_for_idle();
    idle_cycles(1);
    while (awaited != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_hex();
    case ($urandom_range(0, 4))
      0: return 8'h30 + 8'($urandom_range(0, 9));
      1: return 8'h61 + 8'($urandom_range(0, 5));
      2: return 8'h41 + 8'($urandom_range(0, 5));
      3: return 8'h30 + 8'($urandom_range(0, 9));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_plain();
    case ($urandom_range(0, 2))
      0: return 8'h61 + 8'($urandom_range(0, 25));
      1: return 8'h30 + 8'($urandom_range(0, 9));
      default: return 8'($urandom_range(8'h21, 8'h7e));
    endcase
  endfunction

  // whitespace or '?': dropped in body mode
  function automatic logic [7:0] pick_filler();
    case ($urandom_range(0, 2))
      0: return fppd_pkg::CHAR_SPACE;
      1: return fppd_pkg::CHAR_QMARK;
      default: return 8'($urandom_range(8'h09, 8'h0d));
    endcase
  endfunction

  task automatic send_piece();
    int r;
    r = $urandom_range(0, 99);
    if (r < 18) begin
      send_item(fppd_pkg::CHAR_PERCENT, 1'b0);
      if ($urandom_range(0, 5) == 0) send_item(pick_filler(), 1'b0);
      send_item(pick_hex(), 1'b0);
      if ($urandom_range(0, 5) == 0) send_item(pick_filler(), 1'b0);
      send_item(pick_hex(), 1'b0);
    end else if (r < 24) begin
      send_item(pick_filler(), 1'b0);
    end else if (r < 30) begin
      send_item(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      send_item(pick_plain(), 1'b0);
    end
  endtask

  task automatic send_param();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      repeat ($urandom_range(1, 6)) send_item(8'($urandom_range(0, 255)), 1'b0);
    end else if (r < 11) begin
      send_item(8'($urandom_range(0, 255)), 1'b1);
    end else begin
      repeat ($urandom_range(0, 6)) send_piece();
      if ($urandom_range(0, 3) != 0) send_item(fppd_pkg::CHAR_EQ, 1'b0);
      repeat ($urandom_range(0, 8)) send_piece();
      case ($urandom_range(0, 5))
        0, 1: send_item(fppd_pkg::CHAR_AMP, 1'b0);
        2: send_item(fppd_pkg::CHAR_SPACE, 1'b0);
        3: send_item(8'h0b, 1'b0);
        4: send_item(fppd_pkg::CHAR_NUL, 1'b0);
        default: send_item(8'($urandom_range(0, 255)), 1'b1);
      endcase
    end
  endtask

  initial begin
    int target;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_byte_i      = 8'd0;
    end_of_input_i = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = fppd_pkg::CFG_NAME_CAP;
    cfg_data_i     = 8'd0;
    hold_req       = 1'b0;
    burst_left     = 0;
    gap_max        = 0;
    items_sent     = 0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset capacities: skipped separators, escapes incl. bad digits, name then value
    send_text("& %41%z9%7g=%fF");
    send_item(8'h80, 1'b0);
    send_item(fppd_pkg::CHAR_AMP, 1'b0);
    // escape cut short by NUL, then by end of input
    send_text("%4");
    send_item(fppd_pkg::CHAR_NUL, 1'b0);
    send_item(fppd_pkg::CHAR_PERCENT, 1'b0);
    send_item(8'hff, 1'b1);
    send_text("x\t");

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_for_idle();
      case (phase)
        0: set_caps(8'd0, 8'd1, 1'b0);
        1: set_caps(8'd255, 8'd255, 1'b1);
        2: set_caps(8'd3, 8'd5, 1'b0);
        3: set_caps(8'd1, 8'd0, 1'b1);
        4: set_caps(8'd8, 8'd16, 1'b1);
        5: set_caps(8'd0, 8'd255, 1'b0);
        6: set_caps(8'd255, 8'd1, 1'b1);
        7: set_caps(fppd_pkg::NAME_CAP_RST, fppd_pkg::VALUE_CAP_RST, 1'b0);
        default: set_caps(8'($urandom_range(0, 12)), 8'($urandom_range(1, 20)),
                          1'($urandom_range(0, 1)));
      endcase
      gap_max = (phase % 3) * 4;
      target  = items_sent + PHASE_ITEMS;
      if (phase == HOLD_PHASE) begin
        repeat (10) send_param();
        hold_req = 1'b1;
      end
      while (items_sent < target) send_param();
    end
    wait_for_idle();

    if (mismatches == 0 && awaited == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
src/fppd_pkg.sv
src/form_param_percent_decoder.sv
tb/sv/fppd_param_monitor.sv
tb/sv/testbench.sv
